// ===== design/iiea_pkg.sv =====
// Package for the indexed insert/erase array.
// Holds request and status codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package iiea_pkg;

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_INSERT = 3'd2;
    localparam logic [2:0] REQ_ERASE  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam int REQ_BITS   = 3;
    localparam int POS_BITS   = 5;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;

    typedef struct packed {
        logic latch;
        logic init_up;
        logic init_dn;
        logic rd_issue;
        logic shift_rd;
        logic shift_wr;
        logic apply;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic shift_up;
        logic shift_dn;
        logic rd_ok;
        logic shift_last;
        logic out_free;
    } t_stat;

endpackage

// ===== design/iiea_ram.sv =====
// Generic memory with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module iiea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/iiea_ctrl.sv =====
// Controller state machine for the indexed insert/erase array.
// Depends on iiea_pkg for the command and status structs.
`timescale 1ns / 1ps

module iiea_ctrl
    import iiea_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_RD     = 7'b0000100,
        S_WR     = 7'b0001000,
        S_APPLY  = 7'b0010000,
        S_RDWAIT = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.shift_up) begin
                    o_cmd.init_up = 1'b1;
                    n_state       = S_RD;
                end else if (i_stat.shift_dn) begin
                    o_cmd.init_dn = 1'b1;
                    n_state       = S_RD;
                end else if (i_stat.rd_ok) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RDWAIT;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_RD: begin
                o_cmd.shift_rd = 1'b1;
                n_state        = S_WR;
            end
            S_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = i_stat.shift_last ? S_APPLY : S_RD;
            end
            S_APPLY, S_RDWAIT: begin
                o_cmd.apply = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ===== design/iiea_dp.sv =====
// Datapath for the indexed insert/erase array: request registers, count,
// shift index, element memory and output register. Depends on iiea_pkg, iiea_ram.
`timescale 1ns / 1ps

module iiea_dp
    import iiea_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ELEM_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [REQ_BITS-1:0]   i_req_type,
    input  logic [POS_BITS-1:0]   i_position,
    input  logic [VALUE_BITS-1:0] i_write_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_status,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic [COUNT_BITS-1:0] o_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;
    localparam int MAXW = (ELEM_BITS > VALUE_BITS) ? ELEM_BITS : VALUE_BITS;

    logic [REQ_BITS-1:0]   r_req;
    logic [POS_BITS-1:0]   r_pos;
    logic [ELEM_BITS-1:0]  r_data;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [AW-1:0]         r_idx;
    logic                  r_up;
    logic                  r_res_status;
    logic [VALUE_BITS-1:0] r_res_rdval;
    logic [COUNT_BITS-1:0] r_res_count;
    logic                  r_out_valid;
    logic                  r_out_status;
    logic [VALUE_BITS-1:0] r_out_rdval;
    logic [COUNT_BITS-1:0] r_out_count;

    logic [CMPW-1:0]       count_x;
    logic [CMPW-1:0]       pos_x;
    logic [CMPW-1:0]       idx_x;
    logic [CMPW-1:0]       ncount_x;
    logic [AW-1:0]         count_a;
    logic [AW-1:0]         pos_a;
    logic [MAXW-1:0]       wval_x;
    logic [MAXW-1:0]       rdata_x;
    logic                  full;
    logic                  ins_ok;
    logic                  pos_lt;
    logic                  ok;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ELEM_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ELEM_BITS-1:0]  ram_rdata;

    assign count_x = CMPW'(r_count);
    assign pos_x   = CMPW'(r_pos);
    assign idx_x   = CMPW'(r_idx);
    assign count_a = count_x[AW-1:0];
    assign pos_a   = pos_x[AW-1:0];
    assign wval_x  = MAXW'(i_write_value);
    assign rdata_x = MAXW'(ram_rdata);
    assign full    = (r_count == CW'(DEPTH));
    assign ins_ok  = (pos_x <= count_x) && !full;
    assign pos_lt  = (pos_x < count_x);

    always_comb begin
        unique case (r_req) inside
            REQ_PUSH:             ok = !full;
            REQ_POP, REQ_CLEAR:   ok = 1'b1;
            REQ_INSERT:           ok = ins_ok;
            REQ_ERASE, REQ_READ:  ok = pos_lt;
            default:              ok = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (ok) begin
            unique case (r_req) inside
                REQ_PUSH, REQ_INSERT: n_count = r_count + CW'(1);
                REQ_POP:              n_count = (r_count != '0) ? r_count - CW'(1) : r_count;
                REQ_ERASE:            n_count = r_count - CW'(1);
                REQ_CLEAR:            n_count = '0;
                default:              n_count = r_count;
            endcase
        end
    end

    assign ncount_x = CMPW'(n_count);

    always_comb begin
        o_stat.shift_up = (r_req == REQ_INSERT) && ins_ok && (pos_x != count_x);
        o_stat.shift_dn = (r_req == REQ_ERASE) && pos_lt
                          && ({1'b0, pos_x} + (CMPW + 1)'(1) < {1'b0, count_x});
        o_stat.rd_ok    = (r_req == REQ_READ) && pos_lt;
        if (r_up) begin
            o_stat.shift_last = ({1'b0, idx_x} == {1'b0, pos_x} + (CMPW + 1)'(1));
        end else begin
            o_stat.shift_last = ({1'b0, idx_x} + (CMPW + 1)'(2) == {1'b0, count_x});
        end
        o_stat.out_free = !r_out_valid || i_ready;
    end

    always_comb begin
        ram_we    = i_cmd.shift_wr
                    || (i_cmd.apply && ok && (r_req == REQ_PUSH || r_req == REQ_INSERT));
        ram_waddr = i_cmd.shift_wr ? r_idx : ((r_req == REQ_PUSH) ? count_a : pos_a);
        ram_wdata = i_cmd.shift_wr ? ram_rdata : r_data;
        ram_re    = i_cmd.rd_issue || i_cmd.shift_rd;
        if (i_cmd.shift_rd) begin
            ram_raddr = r_up ? r_idx - AW'(1) : r_idx + AW'(1);
        end else begin
            ram_raddr = pos_a;
        end
    end

    iiea_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req  <= i_req_type;
            r_pos  <= i_position;
            r_data <= wval_x[ELEM_BITS-1:0];
        end
        if (i_cmd.init_up) begin
            r_idx <= count_a;
            r_up  <= 1'b1;
        end else if (i_cmd.init_dn) begin
            r_idx <= pos_a;
            r_up  <= 1'b0;
        end else if (i_cmd.shift_wr) begin
            r_idx <= r_up ? r_idx - AW'(1) : r_idx + AW'(1);
        end
        if (i_cmd.apply) begin
            r_res_status <= ok ? ST_OK : ST_ERR;
            r_res_rdval  <= o_stat.rd_ok ? rdata_x[VALUE_BITS-1:0] : '0;
            r_res_count  <= ncount_x[COUNT_BITS-1:0];
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_rdval  <= r_res_rdval;
            r_out_count  <= r_res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_count <= n_count;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_rdval;
    assign o_count      = r_out_count;

endmodule

// ===== design/indexed_insert_erase_array.sv =====
// Indexed insert/erase array: push, pop, insert, erase, read and clear on an ordered array.
// Push, pop, clear and rejected requests pass through S_DECIDE and S_DONE before o_valid;
// a read adds S_RDWAIT. Insert and erase add an S_RD/S_WR pair per moved element, plus
// S_APPLY when any moves. The result is registered once the output register is free, and
// the next beat is then accepted even if that result is not yet taken.
// Reset empties the array and the output register; the element memory is not cleared.
`timescale 1ns / 1ps

module indexed_insert_erase_array
    import iiea_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ELEM_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [REQ_BITS-1:0]   i_req_type,
    input  logic [POS_BITS-1:0]   i_position,
    input  logic [VALUE_BITS-1:0] i_write_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_status,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic [COUNT_BITS-1:0] o_count
);

    t_cmd  cmd;
    t_stat stat;

    iiea_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    iiea_dp #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_count       (o_count)
    );

endmodule
